// ===== hw/rtl/vft_pkg.sv =====
// ----------------------------------------------------------------------------
// vft_pkg
// Shared types and constants of the variable refresh flip timing tracker.
// ----------------------------------------------------------------------------
package vft_pkg;

  // width of the wrapping period and bad timestamp counters
  localparam int unsigned COUNT_W   = 32;
  // width of the counter fields in a result
  localparam int unsigned RES_CNT_W = 32;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SERIAL_W  = 64;
  localparam int unsigned SEQ_W     = 32;
  localparam int unsigned TIME_W    = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_FLIP        = 3'd0,
    CMD_INITIAL     = 3'd1,
    CMD_SUSPEND_OFF = 3'd2,
    CMD_ACQUIRE_OFF = 3'd3,
    CMD_RESTORED    = 3'd4,
    CMD_SESSION_ON  = 3'd5
  } vft_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TS_MONOTONIC = 3'd0,
    CFG_VRR_CTRL     = 3'd1,
    CFG_ORIG_ENABLED = 3'd2,
    CFG_PROP_PRESENT = 3'd3
  } vft_cfg_idx_e;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic                want_on;
    logic                hw_on;
    logic                hw_on_ok;
    logic [SERIAL_W-1:0] mode_serial;
    logic [SEQ_W-1:0]    flip_seq;
    logic [TIME_W-1:0]   flip_time_ns;
    logic                time_present;
  } vft_in_t;

  typedef struct packed {
    logic                 effective_on;
    logic                 readback_confirmed;
    logic                 session_on;
    logic [SEQ_W-1:0]     last_flip_seq;
    logic [TIME_W-1:0]    last_flip_time_ns;
    logic [TIME_W-1:0]    flip_interval_ns;
    logic                 timing_valid;
    logic [RES_CNT_W-1:0] enabled_periods;
    logic [RES_CNT_W-1:0] disabled_periods;
    logic [RES_CNT_W-1:0] bad_time_count;
  } vft_out_t;

  // configuration register contents
  typedef struct packed {
    logic ts_monotonic;
    logic vrr_ctrl;
    logic orig_enabled;
    logic prop_present;
  } vft_cfg_t;

endpackage

// ===== hw/rtl/vft_if.sv =====
// ----------------------------------------------------------------------------
// vft channel interfaces
// Valid/ready channels for event requests, results and register writes.
// ----------------------------------------------------------------------------
interface vft_in_if;
  logic             valid;
  logic             ready;
  vft_pkg::vft_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface vft_out_if;
  logic              valid;
  logic              ready;
  vft_pkg::vft_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface vft_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [vft_pkg::CFG_IDX_W-1:0]   index;
  logic                            data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/vft_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// vft_cfg_regs
// Configuration register file, one write per cycle, always ready.
// ----------------------------------------------------------------------------
module vft_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  vft_cfg_if.sink           cfg_i,
  output vft_pkg::vft_cfg_t cfg_o
);
  import vft_pkg::*;

  vft_cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (vft_cfg_idx_e'(cfg_i.index))
        CFG_TS_MONOTONIC: cfg_d.ts_monotonic = cfg_i.data;
        CFG_VRR_CTRL:     cfg_d.vrr_ctrl     = cfg_i.data;
        CFG_ORIG_ENABLED: cfg_d.orig_enabled = cfg_i.data;
        CFG_PROP_PRESENT: cfg_d.prop_present = cfg_i.data;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/vft_in_stage.sv =====
// ----------------------------------------------------------------------------
// vft_in_stage
// Input register for event requests.
// ----------------------------------------------------------------------------
module vft_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  vft_in_if.sink           in_i,
  input  logic             adv_i,
  output logic             valid_o,
  output vft_pkg::vft_in_t item_o
);
  import vft_pkg::*;

  logic    valid_q, valid_d;
  logic    load;
  vft_in_t item_q;

  // take a request when empty or when the held one moves on
  assign in_i.ready = !valid_q || adv_i;
  assign load       = in_i.valid && in_i.ready;
  assign valid_d    = in_i.ready ? in_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_i.payload;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hw/rtl/vft_out_stage.sv =====
// ----------------------------------------------------------------------------
// vft_out_stage
// Result register; reports whether it can take a new result this cycle.
// ----------------------------------------------------------------------------
module vft_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  vft_pkg::vft_out_t res_i,
  output logic              free_o,
  vft_out_if.source         out_o
);
  import vft_pkg::*;

  logic     valid_q, valid_d;
  vft_out_t res_q;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (adv_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid   = valid_q;
  assign out_o.payload = res_q;

endmodule

// ===== hw/rtl/vft_core.sv =====
// ----------------------------------------------------------------------------
// vft_core
// Tracker state and its single-pass update for one event.
// ----------------------------------------------------------------------------
module vft_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  vft_pkg::vft_in_t  item_i,
  input  vft_pkg::vft_cfg_t cfg_i,
  output vft_pkg::vft_out_t res_o
);
  import vft_pkg::*;

  logic                effective_q, effective_d;
  logic                confirmed_q, confirmed_d;
  logic                session_q, session_d;
  logic                serial_known_q, serial_known_d;
  logic [SERIAL_W-1:0] last_serial_q, last_serial_d;
  logic [COUNT_W-1:0]  enabled_cnt_q, enabled_cnt_d;
  logic [COUNT_W-1:0]  disabled_cnt_q, disabled_cnt_d;
  logic [COUNT_W-1:0]  bad_cnt_q, bad_cnt_d;
  logic [SEQ_W-1:0]    report_seq_q, report_seq_d;
  logic [TIME_W-1:0]   report_time_q, report_time_d;
  logic [TIME_W-1:0]   report_int_q, report_int_d;
  logic                report_valid_q, report_valid_d;
  logic                base_known_q, base_known_d;
  logic [SEQ_W-1:0]    base_seq_q, base_seq_d;
  logic [TIME_W-1:0]   base_time_q, base_time_d;

  logic                inc_en, inc_dis, inc_bad;
  logic                flip_eff, serial_chg, flip_new_period, base_live;
  logic                time_ok, seq_ok, time_rises;
  logic [SEQ_W-1:0]    seq_diff;
  logic [TIME_W-1:0]   interval;

  // flip checks against the held baseline
  assign flip_eff   = item_i.hw_on_ok && item_i.hw_on;
  assign serial_chg = !serial_known_q || (item_i.mode_serial != last_serial_q);
  assign flip_new_period = (flip_eff != effective_q) || serial_chg;
  assign base_live  = base_known_q && !flip_new_period;
  assign time_ok    = item_i.time_present && cfg_i.ts_monotonic &&
                      (item_i.flip_time_ns != '0);
  assign seq_diff   = item_i.flip_seq - base_seq_q;
  // half-range compare; two zero sequences count as in order
  assign seq_ok     = ((base_seq_q == '0) && (item_i.flip_seq == '0)) ||
                      ((seq_diff != '0) && !seq_diff[SEQ_W-1]);
  assign time_rises = item_i.flip_time_ns > base_time_q;
  assign interval   = item_i.flip_time_ns - base_time_q;

  always_comb begin
    effective_d    = effective_q;
    confirmed_d    = confirmed_q;
    session_d      = session_q;
    serial_known_d = serial_known_q;
    last_serial_d  = last_serial_q;
    report_seq_d   = report_seq_q;
    report_time_d  = report_time_q;
    report_int_d   = report_int_q;
    report_valid_d = report_valid_q;
    base_known_d   = base_known_q;
    base_seq_d     = base_seq_q;
    base_time_d    = base_time_q;
    inc_en         = 1'b0;
    inc_dis        = 1'b0;
    inc_bad        = 1'b0;

    unique case (vft_cmd_e'(item_i.command))
      CMD_FLIP: begin
        effective_d    = flip_eff;
        confirmed_d    = item_i.hw_on_ok &&
                         (item_i.hw_on == item_i.want_on);
        inc_en         = flip_new_period && flip_eff;
        inc_dis        = flip_new_period && !flip_eff;
        serial_known_d = 1'b1;
        last_serial_d  = item_i.mode_serial;
        report_seq_d   = item_i.flip_seq;
        report_time_d  = '0;
        report_int_d   = '0;
        report_valid_d = 1'b0;
        if (!time_ok) begin
          inc_bad      = 1'b1;
          base_known_d = 1'b0;
        end else if (base_live && !(seq_ok && time_rises)) begin
          // out of order: restart the baseline at this flip
          inc_bad      = 1'b1;
          base_known_d = 1'b1;
          base_seq_d   = item_i.flip_seq;
          base_time_d  = item_i.flip_time_ns;
        end else begin
          base_known_d   = 1'b1;
          base_seq_d     = item_i.flip_seq;
          base_time_d    = item_i.flip_time_ns;
          report_time_d  = item_i.flip_time_ns;
          report_int_d   = base_live ? interval : '0;
          report_valid_d = 1'b1;
        end
      end
      CMD_INITIAL: begin
        effective_d    = flip_eff;
        confirmed_d    = item_i.hw_on_ok;
        serial_known_d = item_i.mode_serial != '0;
        last_serial_d  = item_i.mode_serial;
        inc_en         = flip_eff;
        inc_dis        = !flip_eff;
        report_seq_d   = '0;
        report_time_d  = '0;
        report_int_d   = '0;
        report_valid_d = 1'b0;
        base_known_d   = 1'b0;
      end
      CMD_SUSPEND_OFF: begin
        inc_dis        = effective_q;
        effective_d    = 1'b0;
        confirmed_d    = cfg_i.vrr_ctrl;
        session_d      = 1'b0;
        report_seq_d   = '0;
        report_time_d  = '0;
        report_int_d   = '0;
        report_valid_d = 1'b0;
        base_known_d   = 1'b0;
      end
      CMD_ACQUIRE_OFF: begin
        effective_d    = 1'b0;
        confirmed_d    = cfg_i.vrr_ctrl;
        report_seq_d   = '0;
        report_time_d  = '0;
        report_int_d   = '0;
        report_valid_d = 1'b0;
        base_known_d   = 1'b0;
      end
      CMD_RESTORED: begin
        inc_en         = (effective_q != cfg_i.orig_enabled) && cfg_i.orig_enabled;
        inc_dis        = (effective_q != cfg_i.orig_enabled) && !cfg_i.orig_enabled;
        effective_d    = cfg_i.orig_enabled;
        confirmed_d    = cfg_i.prop_present;
        session_d      = 1'b0;
        report_seq_d   = '0;
        report_time_d  = '0;
        report_int_d   = '0;
        report_valid_d = 1'b0;
        base_known_d   = 1'b0;
      end
      CMD_SESSION_ON: begin
        session_d = 1'b1;
      end
      default: begin
        // unused codes leave the state alone
        session_d = session_q;
      end
    endcase
  end

  assign enabled_cnt_d  = inc_en  ? enabled_cnt_q  + COUNT_W'(1) : enabled_cnt_q;
  assign disabled_cnt_d = inc_dis ? disabled_cnt_q + COUNT_W'(1) : disabled_cnt_q;
  assign bad_cnt_d      = inc_bad ? bad_cnt_q      + COUNT_W'(1) : bad_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      effective_q    <= 1'b0;
      confirmed_q    <= 1'b0;
      session_q      <= 1'b1;
      serial_known_q <= 1'b0;
      enabled_cnt_q  <= '0;
      disabled_cnt_q <= '0;
      bad_cnt_q      <= '0;
      report_seq_q   <= '0;
      report_time_q  <= '0;
      report_int_q   <= '0;
      report_valid_q <= 1'b0;
      base_known_q   <= 1'b0;
    end else if (adv_i) begin
      effective_q    <= effective_d;
      confirmed_q    <= confirmed_d;
      session_q      <= session_d;
      serial_known_q <= serial_known_d;
      enabled_cnt_q  <= enabled_cnt_d;
      disabled_cnt_q <= disabled_cnt_d;
      bad_cnt_q      <= bad_cnt_d;
      report_seq_q   <= report_seq_d;
      report_time_q  <= report_time_d;
      report_int_q   <= report_int_d;
      report_valid_q <= report_valid_d;
      base_known_q   <= base_known_d;
    end
  end

  // only read while the matching known flag is set
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      last_serial_q <= last_serial_d;
      base_seq_q    <= base_seq_d;
      base_time_q   <= base_time_d;
    end
  end

  always_comb begin
    res_o.effective_on       = effective_d;
    res_o.readback_confirmed = confirmed_d;
    res_o.session_on         = session_d;
    res_o.last_flip_seq      = report_seq_d;
    res_o.last_flip_time_ns  = report_time_d;
    res_o.flip_interval_ns   = report_int_d;
    res_o.timing_valid       = report_valid_d;
    res_o.enabled_periods    = RES_CNT_W'(enabled_cnt_d);
    res_o.disabled_periods   = RES_CNT_W'(disabled_cnt_d);
    res_o.bad_time_count     = RES_CNT_W'(bad_cnt_d);
  end

endmodule

// ===== hw/rtl/vrr_flip_timing_tracker.sv =====
// ----------------------------------------------------------------------------
// vrr_flip_timing_tracker
// Tracks variable refresh state and flip timing across display events.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      carries
//  -------  ---  -------------  ---------------------------------------------
//  in_i     in   valid / ready  event request: command, readback, serial,
//                               flip sequence and timestamp
//  out_o    out  valid / ready  one result per request: flags, timing report,
//                               wrapping counters
//  cfg_i    in   valid / ready  register write: index, one data bit
//
//  a request is held in the input register, then its result is
//  computed in one pass and lands in the result register; one request
//  per cycle is sustained while out_o takes results
//  the longest path is the 64-bit timestamp compare and subtract against
//  the held baseline, feeding the state and result registers
//  reset clears all tracker state but the serial and baseline values, which
//  are read only under their known flags; the session flag comes up set
//  while a result waits unaccepted, the input register still takes one
//  more request, then in_i.ready drops until out_o moves
module vrr_flip_timing_tracker (
  input  logic      clk_i,
  input  logic      rst_ni,
  vft_in_if.sink    in_i,
  vft_out_if.source out_o,
  vft_cfg_if.sink   cfg_i
);
  import vft_pkg::*;

  logic     item_valid;  // input register holds a request
  vft_in_t  item;
  logic     out_free;    // result register can take a new result
  logic     adv;         // request moves from input to result register
  vft_cfg_t cfg;
  vft_out_t res;

  assign adv = item_valid && out_free;

  // register file for the four configuration bits
  vft_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // input register
  vft_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (adv),
    .valid_o (item_valid),
    .item_o  (item)
  );

  // state update; state commits on the same edge as the result
  vft_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (item),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // result register
  vft_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

  // an accepted timestamp is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload.timing_valid |-> out_o.payload.last_flip_time_ns != '0)
    else $error("timing_valid result with zero timestamp");

  // an interval is only reported for an accepted flip
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload.flip_interval_ns != '0 |-> out_o.payload.timing_valid)
    else $error("interval reported without accepted timestamp");

  // both registers full and the result stalled: no new request may enter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid && out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("request accepted while pipeline is blocked");

  // a held request does not move while the result register is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid && out_o.valid && !out_o.ready |=> item_valid && $stable(item))
    else $error("held request lost during output stall");

endmodule
